### hw/rtl/sttc_pkg.sv
`timescale 1ns / 1ps

package sttc_pkg;

    localparam int unsigned SEED_W     = 16;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned WORD_COUNT = 10;
    localparam int unsigned REF_W      = WORD_W * WORD_COUNT;
    localparam int unsigned CTRL_W     = 40;
    localparam int unsigned CFG_W      = 64;

    localparam logic [2:0]       LAST_ROUND  = 3'd4;
    localparam logic [4:0]       LAST_STEP   = 5'd31;
    localparam logic [NIB_W-1:0] INDEX_START = 4'hF;

    typedef enum logic [1:0] {
        CFG_WORDS_LOW  = 2'd0,
        CFG_WORDS_MID  = 2'd1,
        CFG_WORDS_HIGH = 2'd2,
        CFG_CONTROL    = 2'd3
    } cfg_index_t;

    // Outcome of one step of the trace walk.
    typedef struct packed {
        logic             fail;
        logic [NIB_W-1:0] idx;
        logic [NIB_W-1:0] shift;
    } step_result_t;

    // Bits 5..2 of a reference word rotated left by rot.
    function automatic logic [NIB_W-1:0] ref_nibble(input logic [WORD_W-1:0] word,
                                                    input logic [3:0] rot);
        logic [2*WORD_W-1:0] dbl;
        dbl = {word, word} << rot;
        return dbl[WORD_W+5 -: NIB_W];
    endfunction

endpackage

### hw/rtl/sttc_step_unit.sv
`timescale 1ns / 1ps

module sttc_step_unit (
    input  logic [sttc_pkg::SEED_W-1:0] first_seed,
    input  logic [sttc_pkg::SEED_W-1:0] second_seed,
    input  logic [sttc_pkg::SEED_W-1:0] third_seed,
    input  logic [sttc_pkg::NIB_W-1:0]  idx,
    input  logic [sttc_pkg::NIB_W-1:0]  shift,
    input  logic [2:0]                  round,
    input  logic [4:0]                  step,
    input  logic [sttc_pkg::REF_W-1:0]  ref_words,
    input  logic [sttc_pkg::CTRL_W-1:0] ref_control,
    output sttc_pkg::step_result_t      result
);
    import sttc_pkg::*;

    logic [1:0]        ptr;
    logic [3:0]        word_sel;
    logic [WORD_W-1:0] word;
    logic [NIB_W-1:0]  digit;
    logic [5:0]        ctrl_sel;

    always_comb
    begin
        ptr      = {first_seed[idx], second_seed[idx]};
        // Two reference words per round, the second serving steps 16 to 31.
        word_sel = {round, 1'b0} + {3'd0, step[4]};
        word     = ref_words[word_sel * WORD_W +: WORD_W];
        // Digit 0 is the top nibble of the third seed.
        digit    = third_seed[{~ptr, 2'b00} +: NIB_W];
        ctrl_sel = {round, step[4:2]};

        result.fail  = (step[1:0] == 2'b00) && (ptr[0] != ref_control[ctrl_sel]);
        result.idx   = idx ^ ref_nibble(word, step[3:0]) ^ shift ^ digit;
        result.shift = {shift[NIB_W-2:0], ptr[1]};
    end

endmodule

### hw/rtl/seed_triple_trace_checker.sv
`timescale 1ns / 1ps

// Checks one seed triple per request against the reference trace held in the
// configuration registers. A request is taken only while the checker is idle;
// it then walks up to five rounds of 32 steps, one step per clock through a
// single shared step unit. A mismatch ends the walk at the failing step, and
// a finished walk returns the block to ready. The verdict and the echoed
// seeds sit in an output register, so the next request can be taken while a
// result still waits to be collected; a finished walk holds only if that
// register is still full.
module seed_triple_trace_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // first_seed, second_seed, third_seed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // trace_match, seed_one_echo, seed_two_echo,
                                    // seed_three_echo, zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import sttc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         round_reg, round_next;
    logic [4:0]         step_reg, step_next;
    logic [NIB_W-1:0]   idx_reg, idx_next;
    logic [NIB_W-1:0]   shift_reg, shift_next;
    logic               ok_reg, ok_next;
    logic [SEED_W-1:0]  seed1_reg, seed2_reg, seed3_reg;

    logic [63:0]        words_low_reg, words_mid_reg;
    logic [31:0]        words_high_reg;
    logic [CTRL_W-1:0]  control_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_match_reg;
    logic [SEED_W-1:0]  out_s1_reg, out_s2_reg, out_s3_reg;

    step_result_t       res;
    logic               take_in;
    logic               slot_free;
    logic               load_out;
    logic               load_ok;

    sttc_step_unit u_step (
        .first_seed  (seed1_reg),
        .second_seed (seed2_reg),
        .third_seed  (seed3_reg),
        .idx         (idx_reg),
        .shift       (shift_reg),
        .round       (round_reg),
        .step        (step_reg),
        .ref_words   ({words_high_reg, words_mid_reg, words_low_reg}),
        .ref_control (control_reg),
        .result      (res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign take_in   = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_s3_reg, out_s2_reg, out_s1_reg, out_match_reg};

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        ok_next    = ok_reg;
        load_out   = 1'b0;
        load_ok    = ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                begin
                    state_next = ST_RUN;
                    round_next = 3'd0;
                    step_next  = 5'd0;
                    idx_next   = INDEX_START;
                    shift_next = '0;
                end
            end
            ST_RUN:
            begin
                idx_next   = res.idx;
                shift_next = res.shift;
                step_next  = step_reg + 5'd1;
                if (res.fail || (step_reg == LAST_STEP && round_reg == LAST_ROUND))
                begin
                    ok_next = !res.fail;
                    load_ok = !res.fail;
                    if (slot_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else if (step_reg == LAST_STEP)
                begin
                    // Each round restarts the walk from the same index and a clear shift.
                    round_next = round_reg + 3'd1;
                    idx_next   = INDEX_START;
                    shift_next = '0;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !m_tready) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            round_reg      <= '0;
            step_reg       <= '0;
            idx_reg        <= INDEX_START;
            shift_reg      <= '0;
            ok_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            words_low_reg  <= '0;
            words_mid_reg  <= '0;
            words_high_reg <= '0;
            control_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            shift_reg     <= shift_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_WORDS_LOW:  words_low_reg  <= cfg_data;
                    CFG_WORDS_MID:  words_mid_reg  <= cfg_data;
                    CFG_WORDS_HIGH: words_high_reg <= cfg_data[31:0];
                    CFG_CONTROL:    control_reg    <= cfg_data[CTRL_W-1:0];
                    default:        control_reg    <= control_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            seed1_reg <= s_tdata[15:0];
            seed2_reg <= s_tdata[31:16];
            seed3_reg <= s_tdata[47:32];
        end
        if (load_out)
        begin
            out_match_reg <= load_ok;
            out_s1_reg    <= seed1_reg;
            out_s2_reg    <= seed2_reg;
            out_s3_reg    <= seed3_reg;
        end
    end

endmodule
